@@ hdl/ready_queue_min_priority_top_defines.svh @@
// Assertion macros shared by the ready queue RTL.
`ifndef READY_QUEUE_MIN_PRIORITY_TOP_DEFINES_SVH
`define READY_QUEUE_MIN_PRIORITY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RQMP_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define RQMP_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define RQMP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RQMP_ASSERT_ALWAYS(name, cond, msg)
`define RQMP_ASSERT_SAME(name, ante, cons, msg)
`define RQMP_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

@@ hdl/rqmp_pkg.sv @@
// Shared constants, codes and control/status types of the ready queue.
package rqmp_pkg;

    localparam int DEPTH     = 32;
    localparam int ID_BITS   = 8;
    localparam int PRIO_BITS = 4;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int QLEN_W    = 6;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WORD_W    = ID_BITS + PRIO_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_MIN  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    enq;
        logic    dec;
        logic    scan_start;
        logic    scan;
        logic    shift_start;
        logic    shift;
        logic    issue;
        logic    res_load;
        logic    res_take_best;
        status_t res_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic at_limit;
    } sts_t;

endpackage

@@ hdl/rqmp_dp.sv @@
// Datapath of the ready queue: slot memory, entry count, scan and shift logic, result registers.
module rqmp_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rqmp_pkg::cmd_t                cmd,
    output rqmp_pkg::sts_t                sts,
    input  logic [rqmp_pkg::OP_W-1:0]     s_op,
    input  logic [rqmp_pkg::ID_BITS-1:0]  s_proc_id,
    input  logic [rqmp_pkg::PRIO_BITS-1:0] s_prio_in,
    output logic [rqmp_pkg::ID_BITS-1:0]  m_out_proc_id,
    output logic [rqmp_pkg::PRIO_BITS-1:0] m_out_prio,
    output logic [rqmp_pkg::STATUS_W-1:0] m_status,
    output logic [rqmp_pkg::QLEN_W-1:0]   m_queue_length
);
    import rqmp_pkg::*;

    logic [WORD_W-1:0]    mem [DEPTH];

    op_t                  op_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [PRIO_BITS-1:0] prio_reg;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic                 rvalid_reg;
    logic [IDX_W-1:0]     raddr_reg;
    logic [WORD_W-1:0]    rdata_reg;

    logic                 best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [ID_BITS-1:0]   best_id_reg, best_id_next;
    logic [PRIO_BITS-1:0] best_prio_reg, best_prio_next;

    logic [ID_BITS-1:0]   out_id_reg;
    logic [PRIO_BITS-1:0] out_prio_reg;
    status_t              out_status_reg;
    logic [QLEN_W-1:0]    out_len_reg;

    logic [ID_BITS-1:0]   rd_id;
    logic [PRIO_BITS-1:0] rd_prio;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_W-1:0]    wr_data;

    assign rd_id   = rdata_reg[WORD_W-1:PRIO_BITS];
    assign rd_prio = rdata_reg[PRIO_BITS-1:0];

    // During a shift, the word read from slot k lands in slot k-1.
    assign wr_en   = cmd.enq | (cmd.shift & rvalid_reg);
    assign wr_addr = cmd.enq ? count_reg[IDX_W-1:0] : IDX_W'(raddr_reg - 1'b1);
    assign wr_data = cmd.enq ? {id_reg, prio_reg} : rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue) begin
            rdata_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    always_comb begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        limit_next      = limit_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_id_next    = best_id_reg;
        best_prio_next  = best_prio_reg;

        if (cmd.enq) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.dec) begin
            count_next = count_reg - 1'b1;
        end

        if (cmd.scan_start) begin
            ptr_next        = '0;
            limit_next      = (op_reg == OP_MIN) ? count_reg : CNT_W'(1);
            best_valid_next = 1'b0;
        end else if (cmd.shift_start) begin
            ptr_next   = CNT_W'(best_idx_reg) + 1'b1;
            limit_next = count_reg;
        end else if (cmd.issue) begin
            ptr_next = ptr_reg + 1'b1;
        end

        // Strict less-than keeps the entry nearest the head on a tie.
        if (cmd.scan && rvalid_reg && (!best_valid_reg || rd_prio < best_prio_reg)) begin
            best_valid_next = 1'b1;
            best_idx_next   = raddr_reg;
            best_id_next    = rd_id;
            best_prio_next  = rd_prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            rvalid_reg     <= 1'b0;
            ptr_reg        <= '0;
            limit_reg      <= '0;
            best_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            rvalid_reg     <= cmd.issue;
            ptr_reg        <= ptr_next;
            limit_reg      <= limit_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= op_t'(s_op);
            id_reg   <= s_proc_id;
            prio_reg <= s_prio_in;
        end
        if (cmd.issue) begin
            raddr_reg <= ptr_reg[IDX_W-1:0];
        end
        best_idx_reg  <= best_idx_next;
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
        if (cmd.res_load) begin
            out_id_reg     <= cmd.res_take_best ? best_id_reg : '0;
            out_prio_reg   <= cmd.res_take_best ? best_prio_reg : '0;
            out_status_reg <= cmd.res_status;
            out_len_reg    <= QLEN_W'(count_reg);
        end
    end

    assign sts.op       = op_reg;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CNT_W'(DEPTH));
    assign sts.at_limit = (ptr_reg == limit_reg);

    assign m_out_proc_id  = out_id_reg;
    assign m_out_prio     = out_prio_reg;
    assign m_status       = out_status_reg;
    assign m_queue_length = out_len_reg;

endmodule

@@ hdl/rqmp_ctrl.sv @@
// Controller state machine of the ready queue: request sequencing and output handshake.
module rqmp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  rqmp_pkg::sts_t sts,
    output rqmp_pkg::cmd_t cmd
);
    import rqmp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DECIDE    = 7'b0000010,
        S_SCAN      = 7'b0000100,
        S_SCAN_END  = 7'b0001000,
        S_SHIFT     = 7'b0010000,
        S_SHIFT_END = 7'b0100000,
        S_FINISH    = 7'b1000000
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    m_valid_reg, m_valid_next;
    logic    out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next        = state_reg;
        st_next           = st_reg;
        cmd               = '0;
        cmd.res_status    = st_reg;
        cmd.res_take_best = (sts.op != OP_ENQ) && (st_reg == ST_OK);
        s_ready           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                // No request is taken while reset is held.
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.op == OP_ENQ) begin
                    if (sts.full) begin
                        st_next = ST_FULL;
                    end else begin
                        cmd.enq = 1'b1;
                        st_next = ST_OK;
                    end
                    state_next = S_FINISH;
                end else if (sts.empty) begin
                    st_next    = ST_EMPTY;
                    state_next = S_FINISH;
                end else begin
                    cmd.scan_start = 1'b1;
                    st_next        = ST_OK;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (!sts.at_limit) begin
                    cmd.issue = 1'b1;
                end else begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                if (sts.op == OP_PEEK) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (!sts.at_limit) begin
                    cmd.issue = 1'b1;
                end else begin
                    state_next = S_SHIFT_END;
                end
            end
            S_SHIFT_END: begin
                cmd.dec    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            st_reg      <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hdl/ready_queue_min_priority_top.sv @@
// Top level of the ready queue with enqueue, dequeue, peek and remove-min requests.
//
//   Channel   Direction   Handshake            Payload
//   s_        in          s_valid / s_ready    s_op, s_proc_id, s_prio_in
//   m_        out         m_valid / m_ready    m_out_proc_id, m_out_prio, m_status,
//                                              m_queue_length
//
// One request at a time. Enqueue and any request on an empty queue make no pass over the slot
// memory; peek reads the head slot; dequeue reads the head and then shifts the later slots up by
// one; remove-min makes one pass over the slot memory to find the first entry with the lowest
// priority, then a second pass shifts the later slots up by one.
// Reset (synchronous, active low) empties the queue; no memory clearing is needed.
// A held result does not stop the next request; that request waits in its last cycle.
`include "ready_queue_min_priority_top_defines.svh"

module ready_queue_min_priority_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rqmp_pkg::OP_W-1:0]      s_op,
    input  logic [rqmp_pkg::ID_BITS-1:0]   s_proc_id,
    input  logic [rqmp_pkg::PRIO_BITS-1:0] s_prio_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rqmp_pkg::ID_BITS-1:0]   m_out_proc_id,
    output logic [rqmp_pkg::PRIO_BITS-1:0] m_out_prio,
    output logic [rqmp_pkg::STATUS_W-1:0]  m_status,
    output logic [rqmp_pkg::QLEN_W-1:0]    m_queue_length
);
    import rqmp_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic shown_full;
    logic shown_empty;
    logic fields_zero;

    rqmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rqmp_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_op           (s_op),
        .s_proc_id      (s_proc_id),
        .s_prio_in      (s_prio_in),
        .m_out_proc_id  (m_out_proc_id),
        .m_out_prio     (m_out_prio),
        .m_status       (m_status),
        .m_queue_length (m_queue_length)
    );

    assign shown_full  = m_valid && (m_status == ST_FULL);
    assign shown_empty = m_valid && (m_status == ST_EMPTY);
    assign fields_zero = (m_queue_length == '0) && (m_out_proc_id == '0) && (m_out_prio == '0);

    `RQMP_ASSERT_SAME(a_full_len, shown_full, m_queue_length == QLEN_W'(DEPTH), "full on short queue")
    `RQMP_ASSERT_SAME(a_empty_zero, shown_empty, fields_zero, "empty status with nonzero fields")
    `RQMP_ASSERT_ALWAYS(a_one_write, !(cmd.enq && (cmd.shift || cmd.dec)), "append hits a shift")
    `RQMP_ASSERT_NEXT(a_result_shown, cmd.res_load, m_valid, "loaded result not presented")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the ready queue with enqueue, dequeue, peek and remove-min.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rqmp_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int MIXED_BLOCK  = 40;
    localparam int CALM_TAIL    = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [ID_BITS-1:0]   proc_id;
        logic [PRIO_BITS-1:0] prio;
        status_t              status;
        logic [QLEN_W-1:0]    length;
    } queue_outcome_t;

    typedef struct packed {
        op_t                  op;
        logic [ID_BITS-1:0]   proc_id;
        logic [PRIO_BITS-1:0] prio;
        logic                 typed;
        queue_outcome_t       result;
    } stim_row_t;

    // Rows with typed set carry their result; the rest are checked against the queue model.
    localparam stim_row_t DIRECTED_ROWS [20] = '{
        '{OP_DEQ,  8'h00, 4'h0, 1'b1, '{8'h00, 4'h0, ST_EMPTY, 6'd0}},
        '{OP_PEEK, 8'h00, 4'h0, 1'b1, '{8'h00, 4'h0, ST_EMPTY, 6'd0}},
        '{OP_MIN,  8'h00, 4'h0, 1'b1, '{8'h00, 4'h0, ST_EMPTY, 6'd0}},
        '{OP_ENQ,  8'hFF, 4'hF, 1'b1, '{8'h00, 4'h0, ST_OK,    6'd1}},
        '{OP_PEEK, 8'h00, 4'h0, 1'b1, '{8'hFF, 4'hF, ST_OK,    6'd1}},
        '{OP_ENQ,  8'h00, 4'h0, 1'b1, '{8'h00, 4'h0, ST_OK,    6'd2}},
        '{OP_ENQ,  8'hA5, 4'h0, 1'b1, '{8'h00, 4'h0, ST_OK,    6'd3}},
        '{OP_MIN,  8'h00, 4'h0, 1'b1, '{8'h00, 4'h0, ST_OK,    6'd2}},
        '{OP_MIN,  8'h00, 4'h0, 1'b1, '{8'hA5, 4'h0, ST_OK,    6'd1}},
        '{OP_DEQ,  8'h00, 4'h0, 1'b1, '{8'hFF, 4'hF, ST_OK,    6'd0}},
        '{OP_ENQ,  8'h5A, 4'h7, 1'b1, '{8'h00, 4'h0, ST_OK,    6'd1}},
        '{OP_ENQ,  8'h3C, 4'h3, 1'b1, '{8'h00, 4'h0, ST_OK,    6'd2}},
        '{OP_ENQ,  8'hC3, 4'h3, 1'b1, '{8'h00, 4'h0, ST_OK,    6'd3}},
        '{OP_ENQ,  8'h81, 4'h9, 1'b1, '{8'h00, 4'h0, ST_OK,    6'd4}},
        '{OP_MIN,  8'h12, 4'h5, 1'b0, '0},
        '{OP_DEQ,  8'h34, 4'h6, 1'b0, '0},
        '{OP_PEEK, 8'h56, 4'h7, 1'b0, '0},
        '{OP_MIN,  8'h78, 4'h8, 1'b0, '0},
        '{OP_MIN,  8'h9A, 4'h9, 1'b0, '0},
        '{OP_DEQ,  8'h00, 4'h0, 1'b1, '{8'h00, 4'h0, ST_EMPTY, 6'd0}}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op;
    logic [ID_BITS-1:0]   s_proc_id;
    logic [PRIO_BITS-1:0] s_prio_in;
    logic                 m_valid;
    logic                 m_ready;
    logic [ID_BITS-1:0]   m_out_proc_id;
    logic [PRIO_BITS-1:0] m_out_prio;
    logic [STATUS_W-1:0]  m_status;
    logic [QLEN_W-1:0]    m_queue_length;

    // Model of the queue contents, slot 0 is the head.
    logic [ID_BITS-1:0]   held_ids   [DEPTH];
    logic [PRIO_BITS-1:0] held_prios [DEPTH];
    int                   held_count;

    queue_outcome_t       pending_results [$];
    logic                 row_typed;
    queue_outcome_t       row_result;

    bit idle_enabled;
    bit pressure_armed;
    bit pressure_done;
    int error_count;
    int requests_accepted;
    int results_seen;
    int full_refusals;
    int empty_results;
    int cycle_count;

    ready_queue_min_priority_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_proc_id      (s_proc_id),
        .s_prio_in      (s_prio_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_proc_id  (m_out_proc_id),
        .m_out_prio     (m_out_prio),
        .m_status       (m_status),
        .m_queue_length (m_queue_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one request to the queue model and returns the result it should produce.
    function automatic queue_outcome_t apply_request(input op_t op,
                                                     input logic [ID_BITS-1:0] id,
                                                     input logic [PRIO_BITS-1:0] prio);
        queue_outcome_t res;
        int pos;
        res = '0;
        res.status = ST_OK;
        pos = 0;
        if (op == OP_ENQ) begin
            if (held_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                held_ids[held_count]   = id;
                held_prios[held_count] = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            // Strict less-than keeps the oldest of tied lowest priorities.
            if (op == OP_MIN) begin
                for (int k = 1; k < held_count; k++) begin
                    if (held_prios[k] < held_prios[pos]) pos = k;
                end
            end
            res.proc_id = held_ids[pos];
            res.prio    = held_prios[pos];
            if (op != OP_PEEK) begin
                for (int k = pos; k < held_count - 1; k++) begin
                    held_ids[k]   = held_ids[k + 1];
                    held_prios[k] = held_prios[k + 1];
                end
                held_count--;
            end
        end
        res.length = QLEN_W'(held_count);
        return res;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    always @(posedge aclk) begin : monitor
        queue_outcome_t want;
        queue_outcome_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = apply_request(op_t'(s_op), s_proc_id, s_prio_in);
                if (row_typed) want = row_result;
                pending_results.push_back(want);
                requests_accepted++;
            end
            if (m_valid && m_ready) begin
                got.proc_id = m_out_proc_id;
                got.prio    = m_out_prio;
                got.status  = status_t'(m_status);
                got.length  = m_queue_length;
                results_seen++;
                if (got.status == ST_FULL) full_refusals++;
                if (got.status == ST_EMPTY) empty_results++;
                if (pending_results.size() == 0) begin
                    note_error($sformatf("unexpected result id=%h prio=%h status=%0d len=%0d",
                                         got.proc_id, got.prio, got.status, got.length));
                end else begin
                    want = pending_results.pop_front();
                    if (got.proc_id !== want.proc_id || got.prio !== want.prio ||
                        got.status !== want.status || got.length !== want.length) begin
                        note_error($sformatf(
                            "result %0d expected id=%h prio=%h status=%0d len=%0d, got id=%h prio=%h status=%0d len=%0d",
                            results_seen, want.proc_id, want.prio, want.status, want.length,
                            got.proc_id, got.prio, got.status, got.length));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off that holds back requests behind a held result.
    initial begin : receiver
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (pressure_armed && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one request and returns at the falling edge after it was accepted.
    task automatic send_request(input op_t op, input logic [ID_BITS-1:0] id,
                                input logic [PRIO_BITS-1:0] prio, input logic typed,
                                input queue_outcome_t typed_result);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_proc_id  <= id;
        s_prio_in  <= prio;
        row_typed  <= typed;
        row_result <= typed_result;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random payload; half the priorities come from a narrow range to force ties.
    task automatic offer_op(input op_t op);
        logic [PRIO_BITS-1:0] prio;
        prio = ($urandom_range(0, 1) == 0) ? PRIO_BITS'($urandom_range(0, 3))
                                           : PRIO_BITS'($urandom_range(0, 15));
        send_request(op, ID_BITS'($urandom_range(0, 255)), prio, 1'b0, '0);
    endtask

    initial begin : stimulus
        int blk;
        int rand_sent;
        int pick;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_ENQ;
        s_proc_id      = '0;
        s_prio_in      = '0;
        m_ready        = 1'b0;
        row_typed      = 1'b0;
        row_result     = '0;
        held_count     = 0;
        idle_enabled   = 1'b1;
        pressure_armed = 1'b0;
        pressure_done  = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        blk            = 0;
        rand_sent      = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIRECTED_ROWS[i]) begin
            send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].proc_id, DIRECTED_ROWS[i].prio,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        end

        // Blocks rotate through mixed traffic, filling past full and draining past empty.
        while (rand_sent < RANDOM_ITEMS) begin
            idle_enabled = (rand_sent < RANDOM_ITEMS - CALM_TAIL) && (blk % 4 != 1);
            if (blk == 2) pressure_armed = 1'b1;
            case (blk % 4)
                1: begin
                    while (held_count < DEPTH) begin
                        offer_op(($urandom_range(0, 9) == 0) ? OP_PEEK : OP_ENQ);
                        rand_sent++;
                    end
                    repeat (3) begin
                        offer_op(OP_ENQ);
                        rand_sent++;
                    end
                end
                3: begin
                    while (held_count > 0) begin
                        pick = $urandom_range(0, 9);
                        offer_op((pick == 0) ? OP_PEEK : (pick < 5) ? OP_DEQ : OP_MIN);
                        rand_sent++;
                    end
                    repeat (2) begin
                        offer_op(op_t'($urandom_range(1, 3)));
                        rand_sent++;
                    end
                end
                default: begin
                    repeat (MIXED_BLOCK) begin
                        pick = $urandom_range(0, 9);
                        offer_op((pick < 4) ? OP_ENQ : (pick < 6) ? OP_DEQ :
                                 (pick < 8) ? OP_PEEK : OP_MIN);
                        rand_sent++;
                    end
                end
            endcase
            blk++;
        end
        s_valid <= 1'b0;
        idle_enabled = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests and %0d results: %0d refused enqueues, %0d on empty queue.",
                 requests_accepted, results_seen, full_refusals, empty_results);
        $display("Long result-side hold-off done: %0d, errors counted: %0d",
                 pressure_done, error_count);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
